// ===== rtl/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, constants and helper functions of the audio container sniffer.
// ----------------------------------------------------------------------------
`default_nettype none

package acs_pkg;

   localparam int unsigned POSITION_BITS_DEFAULT = 32;
   localparam logic [31:0] SCAN_LIMIT_RESET      = 32'd1048576;
   localparam logic [31:0] FMT_ID                = 32'h666d_7420;
   localparam logic [7:0]  MP3_FORMAT_TAG        = 8'h55;
   localparam logic [4:0]  FMT_MIN_SIZE          = 5'd16;

   typedef enum logic [2:0] {
      ST_WAV_OK      = 3'd0,
      ST_MP3         = 3'd1,
      ST_TRUNCATED   = 3'd2,
      ST_FMT_SMALL   = 3'd3,
      ST_FMT_MISSING = 3'd4,
      ST_UNSUPPORTED = 3'd5
   } acs_status_type;

   typedef enum logic [2:0] {
      PH_HEADER    = 3'd0,
      PH_NOT_WAV   = 3'd1,
      PH_CHUNK_HDR = 3'd2,
      PH_BODY      = 3'd3,
      PH_DONE      = 3'd4
   } acs_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } acs_req_type;

   typedef struct packed {
      acs_status_type status;
      logic [15:0]    format_tag;
      logic [15:0]    channel_count;
      logic [15:0]    bits_per_sample;
      logic [31:0]    samples_per_sec;
   } acs_rsp_type;

   function automatic logic [7:0] riff_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h52;
         2'd1:    c = 8'h49;
         default: c = 8'h46;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] wave_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h57;
         2'd1:    c = 8'h41;
         2'd2:    c = 8'h56;
         default: c = 8'h45;
      endcase
      return c;
   endfunction

   function automatic logic frame_ok(input logic [7:0] first,
                                     input logic [7:0] second,
                                     input logic [7:0] third);
      logic sync;
      logic fields;
      sync   = (first == 8'hff) && (second[7:5] == 3'b111);
      fields = (second[4:3] != 2'd1) && (second[2:1] != 2'd0) &&
               (third[7:4] != 4'd0) && (third[7:4] != 4'd15) && (third[3:2] != 2'd3);
      return sync && fields;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/audio_container_sniffer_core.sv =====
// ----------------------------------------------------------------------------
// audio_container_sniffer_core
// Classifies a byte stream as RIFF/WAVE (with fmt fields) or MPEG audio.
// ----------------------------------------------------------------------------
// One file byte is taken per clock cycle with no gaps required. Each byte is
// registered, processed by the parser from the input register, and the
// verdict for the byte flagged last is registered in the result register,
// which drives rsp_*. The only stall is a last byte waiting in the input
// register while a previous verdict still sits untaken in the result
// register. After a verdict the parser is back at its reset state; the next
// byte opens a new file. csr_wr_data sets the scan limit (reset 1048576): an
// MPEG frame header counts only if it starts before byte scan_limit - 3.
`default_nettype none

module audio_container_sniffer_core #(
   parameter int unsigned POSITION_BITS = acs_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire acs_pkg::acs_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output acs_pkg::acs_rsp_type      rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [31:0]          csr_wr_data
);

   logic [31:0]          scan_limit_ff;
   logic                 stage_valid;
   acs_pkg::acs_req_type stage_item;
   logic                 slot_free;
   logic                 advance;
   logic                 result_valid;
   acs_pkg::acs_rsp_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= acs_pkg::SCAN_LIMIT_RESET;
      end else if (csr_wr_en) begin
         scan_limit_ff <= csr_wr_data;
      end
   end

   assign advance = stage_valid && (!stage_item.last || slot_free);

   acs_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   acs_parser #(
      .POSITION_BITS (POSITION_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item         (stage_item),
      .scan_limit   (scan_limit_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   acs_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_data (result),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/acs_input_stage.sv =====
// ----------------------------------------------------------------------------
// acs_input_stage
// Input register: holds one byte transaction until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_input_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire acs_pkg::acs_req_type req_data,
   input  wire logic                 advance,
   output logic                      stage_valid,
   output acs_pkg::acs_req_type      stage_item
);

   logic                 valid_ff;
   logic                 valid_in;
   acs_pkg::acs_req_type item_ff;

   assign req_ready   = !valid_ff || advance;
   assign valid_in    = req_ready ? req_valid : valid_ff;
   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/acs_parser.sv =====
// ----------------------------------------------------------------------------
// acs_parser
// Per-byte file state: RIFF/WAVE chunk walker, fmt capture, MPEG sync search
// and the verdict on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_parser #(
   parameter int unsigned POSITION_BITS = acs_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire acs_pkg::acs_req_type item,
   input  wire logic [31:0]          scan_limit,
   output logic                      result_valid,
   output acs_pkg::acs_rsp_type      result
);

   localparam int unsigned CMP_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;

   acs_pkg::acs_phase_type   phase_ff, phase_in;
   logic [23:0]              recent_ff, recent_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     frame_seen_ff, frame_seen_in;
   logic [63:0]              hdr_ff, hdr_in;
   logic [32:0]              skip_ff, skip_in;
   logic                     small_ff, small_in;
   logic [4:0]               body_off_ff, body_off_in;
   logic [15:0]              tag_ff, tag_in;
   logic [15:0]              ch_ff, ch_in;
   logic [31:0]              rate_ff, rate_in;
   logic [15:0]              bits_ff, bits_in;

   logic [7:0]               b;
   logic [31:0]              size_cur;
   logic [31:0]              size_new;
   logic                     fmt_cur;
   logic                     fmt_new;
   logic                     pad_cur;
   logic                     in_window;
   logic                     clear;

   assign b        = item.data_byte;
   assign size_cur = {hdr_ff[7:0], hdr_ff[15:8], hdr_ff[23:16], hdr_ff[31:24]};
   assign fmt_cur  = (hdr_ff[63:32] == acs_pkg::FMT_ID);
   assign pad_cur  = size_cur[0];
   assign size_new = {hdr_in[7:0], hdr_in[15:8], hdr_in[23:16], hdr_in[31:24]};
   assign fmt_new  = (hdr_in[63:32] == acs_pkg::FMT_ID);

   assign in_window = (pos_ff > POSITION_BITS'(2)) &&
                      (CMP_BITS'(pos_ff) < CMP_BITS'(scan_limit));
   assign frame_seen_in = frame_seen_ff ||
                          (in_window && acs_pkg::frame_ok(recent_ff[23:16], recent_ff[15:8],
                                                          recent_ff[7:0]));
   assign recent_in = {recent_ff[15:0], b};
   assign pos_in    = (&pos_ff) ? pos_ff : pos_ff + POSITION_BITS'(1);

   always_comb begin
      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      skip_in     = skip_ff;
      small_in    = small_ff;
      body_off_in = body_off_ff;
      tag_in      = tag_ff;
      ch_in       = ch_ff;
      rate_in     = rate_ff;
      bits_in     = bits_ff;
      case (phase_ff)
         acs_pkg::PH_HEADER: begin
            if ((pos_ff < POSITION_BITS'(4)) && (b != acs_pkg::riff_char(pos_ff[1:0]))) begin
               phase_in = acs_pkg::PH_NOT_WAV;
            end else if ((pos_ff >= POSITION_BITS'(8)) && (pos_ff < POSITION_BITS'(12)) &&
                         (b != acs_pkg::wave_char(pos_ff[1:0]))) begin
               phase_in = acs_pkg::PH_NOT_WAV;
            end else if (pos_ff == POSITION_BITS'(11)) begin
               phase_in = acs_pkg::PH_CHUNK_HDR;
               hdr_in   = '0;
               skip_in  = '0;
            end
         end
         acs_pkg::PH_CHUNK_HDR: begin
            hdr_in = {hdr_ff[55:0], b};
            if (skip_ff < 33'd7) begin
               skip_in = skip_ff + 33'd1;
            end else if (size_new == 32'd0) begin
               if (fmt_new) begin
                  phase_in = acs_pkg::PH_DONE;
                  small_in = 1'b1;
               end
               skip_in = '0;
            end else begin
               skip_in     = {1'b0, size_new} + 33'(size_new[0]);
               body_off_in = '0;
               phase_in    = acs_pkg::PH_BODY;
            end
         end
         acs_pkg::PH_BODY: begin
            if (fmt_cur) begin
               case (body_off_ff)
                  5'd0:    tag_in[7:0]    = tag_ff[7:0]    | b;
                  5'd1:    tag_in[15:8]   = tag_ff[15:8]   | b;
                  5'd2:    ch_in[7:0]     = ch_ff[7:0]     | b;
                  5'd3:    ch_in[15:8]    = ch_ff[15:8]    | b;
                  5'd4:    rate_in[7:0]   = rate_ff[7:0]   | b;
                  5'd5:    rate_in[15:8]  = rate_ff[15:8]  | b;
                  5'd6:    rate_in[23:16] = rate_ff[23:16] | b;
                  5'd7:    rate_in[31:24] = rate_ff[31:24] | b;
                  5'd14:   bits_in[7:0]   = bits_ff[7:0]   | b;
                  5'd15:   bits_in[15:8]  = bits_ff[15:8]  | b;
                  default: ;
               endcase
            end
            if (body_off_ff != acs_pkg::FMT_MIN_SIZE) begin
               body_off_in = body_off_ff + 5'd1;
            end
            skip_in = skip_ff - 33'd1;
            if (fmt_cur && (skip_ff == (33'(pad_cur) + 33'd1))) begin
               phase_in = acs_pkg::PH_DONE;
               small_in = (size_cur < 32'(acs_pkg::FMT_MIN_SIZE));
            end else if (skip_ff == 33'd1) begin
               phase_in = acs_pkg::PH_CHUNK_HDR;
               hdr_in   = '0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      result = '0;
      case (phase_in)
         acs_pkg::PH_DONE: begin
            if (small_in) begin
               result.status = acs_pkg::ST_FMT_SMALL;
            end else begin
               result.status          = acs_pkg::ST_WAV_OK;
               result.format_tag      = tag_in;
               result.channel_count   = ch_in;
               result.bits_per_sample = bits_in;
               result.samples_per_sec = rate_in;
            end
         end
         acs_pkg::PH_BODY: begin
            result.status = (skip_in > 33'(size_new[0])) ? acs_pkg::ST_TRUNCATED :
                                                           acs_pkg::ST_FMT_MISSING;
         end
         acs_pkg::PH_CHUNK_HDR: begin
            result.status = acs_pkg::ST_FMT_MISSING;
         end
         default: begin
            if (frame_seen_in) begin
               result.status     = acs_pkg::ST_MP3;
               result.format_tag = 16'(acs_pkg::MP3_FORMAT_TAG);
            end else begin
               result.status = acs_pkg::ST_UNSUPPORTED;
            end
         end
      endcase
   end

   assign result_valid = step && item.last;
   assign clear        = reset || result_valid;

   always_ff @(posedge clock) begin
      if (clear) begin
         phase_ff      <= acs_pkg::PH_HEADER;
         recent_ff     <= '0;
         pos_ff        <= '0;
         frame_seen_ff <= 1'b0;
         hdr_ff        <= '0;
         skip_ff       <= '0;
         small_ff      <= 1'b0;
         body_off_ff   <= '0;
         tag_ff        <= '0;
         ch_ff         <= '0;
         rate_ff       <= '0;
         bits_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         recent_ff     <= recent_in;
         pos_ff        <= pos_in;
         frame_seen_ff <= frame_seen_in;
         hdr_ff        <= hdr_in;
         skip_ff       <= skip_in;
         small_ff      <= small_in;
         body_off_ff   <= body_off_in;
         tag_ff        <= tag_in;
         ch_ff         <= ch_in;
         rate_ff       <= rate_in;
         bits_ff       <= bits_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/acs_output_stage.sv =====
// ----------------------------------------------------------------------------
// acs_output_stage
// Result register: holds one verdict transaction until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_output_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire acs_pkg::acs_rsp_type load_data,
   output logic                      slot_free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output acs_pkg::acs_rsp_type      rsp_data
);

   logic                 valid_ff;
   logic                 valid_in;
   acs_pkg::acs_rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/acs_checker.sv =====
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks of the sniffer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire acs_pkg::acs_rsp_type rsp_data
);

   logic no_fmt_fields;

   assign no_fmt_fields = (rsp_data.channel_count == 16'd0) &&
                          (rsp_data.bits_per_sample == 16'd0) &&
                          (rsp_data.samples_per_sec == 32'd0);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= acs_pkg::ST_UNSUPPORTED)
      else $error("status code out of range");

   a_mp3_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == acs_pkg::ST_MP3 |->
         rsp_data.format_tag == 16'(acs_pkg::MP3_FORMAT_TAG) && no_fmt_fields)
      else $error("mp3 verdict with wrong fields");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != acs_pkg::ST_WAV_OK &&
         rsp_data.status != acs_pkg::ST_MP3 |->
         rsp_data.format_tag == 16'd0 && no_fmt_fields)
      else $error("non-format fields set on error verdict");

endmodule

bind audio_container_sniffer_core acs_checker u_acs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== sim/audio_container_sniffer_core_tb.sv =====
// ----------------------------------------------------------------------------
// audio_container_sniffer_core_tb
// Streams whole files, one byte per transaction, into the container sniffer
// and checks each verdict against a cycle-free model of the parser. Covers
// wave files with every fmt outcome, MPEG frame headers at the scan limit
// edges, random files under several idle and stall mixes, and a long
// result-side hold that backs up the input channel.
// ----------------------------------------------------------------------------
module audio_container_sniffer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] RIFF_WORD    = 32'h5249_4646;
   localparam logic [31:0] WAVE_WORD    = 32'h5741_5645;
   localparam logic [31:0] DATA_ID      = 32'h6461_7461;
   localparam logic [31:0] JUNK_ID      = 32'h4a55_4e4b;
   localparam logic [31:0] LIST_ID      = 32'h4c49_5354;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned PHASE_BYTES  = 150;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   acs_pkg::acs_req_type req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   acs_pkg::acs_rsp_type rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [31:0]          csr_wr_data = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_rsp       = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned bytes_sent     = 0;

   acs_pkg::acs_rsp_type pending_verdicts[$];
   logic [7:0]           file_buf[$];

   // parser model state
   logic [31:0]                               scan_limit_m;
   logic [23:0]                               tail_bytes;
   logic [acs_pkg::POSITION_BITS_DEFAULT-1:0] byte_count;
   logic                                      sync_found;
   acs_pkg::acs_phase_type                    parse_phase;
   logic [63:0]                               hdr_bytes;
   logic [32:0]                               skip_left;
   logic                                      small_fmt;
   logic [15:0]                               fmt_tag_m;
   logic [15:0]                               chan_m;
   logic [31:0]                               rate_m;
   logic [15:0]                               bits_m;

   audio_container_sniffer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic void clear_parse_state();
      tail_bytes  = '0;
      byte_count  = '0;
      sync_found  = 1'b0;
      parse_phase = acs_pkg::PH_HEADER;
      hdr_bytes   = '0;
      skip_left   = '0;
      small_fmt   = 1'b0;
      fmt_tag_m   = '0;
      chan_m      = '0;
      rate_m      = '0;
      bits_m      = '0;
   endfunction

   function automatic logic [31:0] hdr_length(input logic [63:0] h);
      return {h[7:0], h[15:8], h[23:16], h[31:24]};
   endfunction

   function automatic logic mpeg_header_ok(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2);
      return b0 == 8'hff && b1[7:5] == 3'b111 && b1[4:3] != 2'b01 && b1[2:1] != 2'b00 &&
             b2[7:4] != 4'h0 && b2[7:4] != 4'hf && b2[3:2] != 2'b11;
   endfunction

   function automatic bit predict_verdict(input logic [7:0] b, input logic fin,
                                          output acs_pkg::acs_rsp_type v);
      logic [31:0] p;
      logic [31:0] csize;
      logic [32:0] pad;
      logic [32:0] off;
      logic        is_fmt;
      p = byte_count;
      v = '0;
      if (p >= 3 && p < scan_limit_m &&
          mpeg_header_ok(tail_bytes[23:16], tail_bytes[15:8], tail_bytes[7:0]))
         sync_found = 1'b1;
      tail_bytes = {tail_bytes[15:0], b};
      case (parse_phase)
         acs_pkg::PH_HEADER: begin
            if (p < 4 && b != RIFF_WORD[8 * (3 - p[1:0]) +: 8])
               parse_phase = acs_pkg::PH_NOT_WAV;
            else if (p >= 8 && p < 12 && b != WAVE_WORD[8 * (3 - p[1:0]) +: 8])
               parse_phase = acs_pkg::PH_NOT_WAV;
            else if (p == 11) begin
               parse_phase = acs_pkg::PH_CHUNK_HDR;
               hdr_bytes   = '0;
               skip_left   = '0;
            end
         end
         acs_pkg::PH_CHUNK_HDR: begin
            hdr_bytes = {hdr_bytes[55:0], b};
            if (skip_left + 1 < 8) begin
               skip_left = skip_left + 1;
            end else begin
               csize = hdr_length(hdr_bytes);
               if (csize == 0) begin
                  if (hdr_bytes[63:32] == acs_pkg::FMT_ID) begin
                     parse_phase = acs_pkg::PH_DONE;
                     small_fmt   = 1'b1;
                  end
                  skip_left = '0;
               end else begin
                  skip_left   = {1'b0, csize} + csize[0];
                  parse_phase = acs_pkg::PH_BODY;
               end
            end
         end
         acs_pkg::PH_BODY: begin
            csize  = hdr_length(hdr_bytes);
            pad    = {32'd0, csize[0]};
            off    = {1'b0, csize} + pad - skip_left;
            is_fmt = hdr_bytes[63:32] == acs_pkg::FMT_ID;
            if (is_fmt && off < 16) begin
               if (off < 2)
                  fmt_tag_m |= 16'(b) << (8 * off[0]);
               else if (off < 4)
                  chan_m |= 16'(b) << (8 * off[0]);
               else if (off < 8)
                  rate_m |= 32'(b) << (8 * off[1:0]);
               else if (off >= 14)
                  bits_m |= 16'(b) << (8 * off[0]);
            end
            skip_left = skip_left - 1;
            if (is_fmt && skip_left == pad) begin
               parse_phase = acs_pkg::PH_DONE;
               small_fmt   = csize < 16;
            end else if (skip_left == 0) begin
               parse_phase = acs_pkg::PH_CHUNK_HDR;
               hdr_bytes   = '0;
            end
         end
         default: ;
      endcase
      if (byte_count != '1)
         byte_count = byte_count + 1;
      if (!fin)
         return 0;
      csize = hdr_length(hdr_bytes);
      case (parse_phase)
         acs_pkg::PH_DONE: begin
            if (small_fmt) begin
               v.status = acs_pkg::ST_FMT_SMALL;
            end else begin
               v.status          = acs_pkg::ST_WAV_OK;
               v.format_tag      = fmt_tag_m;
               v.channel_count   = chan_m;
               v.bits_per_sample = bits_m;
               v.samples_per_sec = rate_m;
            end
         end
         acs_pkg::PH_BODY:
            v.status = (skip_left > {32'd0, csize[0]}) ? acs_pkg::ST_TRUNCATED :
                                                         acs_pkg::ST_FMT_MISSING;
         acs_pkg::PH_CHUNK_HDR: v.status = acs_pkg::ST_FMT_MISSING;
         default: begin
            if (sync_found) begin
               v.status     = acs_pkg::ST_MP3;
               v.format_tag = 16'(acs_pkg::MP3_FORMAT_TAG);
            end else begin
               v.status = acs_pkg::ST_UNSUPPORTED;
            end
         end
      endcase
      clear_parse_state();
      return 1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : verdict_check
      acs_pkg::acs_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected verdict, status %0d", rsp_data.status));
         end else begin
            want = pending_verdicts.pop_front();
            check_field("status", 32'(rsp_data.status), 32'(want.status));
            check_field("format_tag", 32'(rsp_data.format_tag), 32'(want.format_tag));
            check_field("channel_count", 32'(rsp_data.channel_count),
                        32'(want.channel_count));
            check_field("bits_per_sample", 32'(rsp_data.bits_per_sample),
                        32'(want.bits_per_sample));
            check_field("samples_per_sec", rsp_data.samples_per_sec, want.samples_per_sec);
         end
      end
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      acs_pkg::acs_rsp_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, last: fin};
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (predict_verdict(b, fin, v))
         pending_verdicts.push_back(v);
      bytes_sent++;
   endtask

   task automatic send_file();
      int i;
      for (i = 0; i < file_buf.size(); i++)
         send_byte(file_buf[i], i == file_buf.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_scan_limit(input logic [31:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      scan_limit_m  = value;
   endtask

   function automatic logic [7:0] random_byte();
      return 8'($urandom());
   endfunction

   // bias toward 0xff so near-miss frame syncs show up
   function automatic logic [7:0] noise_byte();
      return ($urandom_range(3) == 0) ? 8'hff : random_byte();
   endfunction

   function automatic void push_text(input logic [31:0] w);
      file_buf.push_back(w[31:24]);
      file_buf.push_back(w[23:16]);
      file_buf.push_back(w[15:8]);
      file_buf.push_back(w[7:0]);
   endfunction

   function automatic void push_le32(input logic [31:0] w);
      file_buf.push_back(w[7:0]);
      file_buf.push_back(w[15:8]);
      file_buf.push_back(w[23:16]);
      file_buf.push_back(w[31:24]);
   endfunction

   function automatic void start_wave();
      file_buf.delete();
      push_text(RIFF_WORD);
      push_le32($urandom());
      push_text(WAVE_WORD);
   endfunction

   function automatic void push_chunk(input logic [31:0] id, input logic [31:0] size,
                                      input int unsigned body_len);
      push_text(id);
      push_le32(size);
      repeat (body_len) file_buf.push_back(random_byte());
   endfunction

   function automatic void push_fmt(input int unsigned size, input logic [15:0] tag,
                                    input logic [15:0] ch, input logic [31:0] rate,
                                    input logic [15:0] bits);
      logic [127:0] body;
      int unsigned  i;
      push_text(acs_pkg::FMT_ID);
      push_le32(size);
      body = {bits, 16'($urandom()), 32'($urandom()), rate, ch, tag};
      for (i = 0; i < size + size % 2; i++)
         file_buf.push_back(i < 16 ? body[8 * i +: 8] : random_byte());
   endfunction

   function automatic void trim_file(input int unsigned n);
      repeat (n) void'(file_buf.pop_back());
   endfunction

   function automatic void set_file(input logic [7:0] a[$]);
      file_buf = a;
   endfunction

   function automatic void build_wave_file();
      int unsigned csize;
      int unsigned fsize;
      int unsigned cut;
      int unsigned pick;
      start_wave();
      repeat ($urandom_range(2)) begin
         csize = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(9);
         if (csize > 64) begin
            push_chunk($urandom(), csize, $urandom_range(5));
            return;
         end
         push_chunk($urandom(), csize, csize + csize % 2);
      end
      pick = $urandom_range(7);
      case (pick)
         0:       fsize = $urandom_range(15);
         1:       fsize = 17;
         2:       fsize = 18;
         3:       fsize = $urandom_range(40, 16);
         default: fsize = 16;
      endcase
      push_fmt(fsize, $urandom(), $urandom(), $urandom(), $urandom());
      if ($urandom_range(1) == 1) begin
         csize = $urandom_range(6);
         push_chunk(DATA_ID, csize, $urandom_range(csize));
      end
      if ($urandom_range(99) < 30) begin
         cut = $urandom_range(file_buf.size(), 1);
         trim_file(file_buf.size() - cut);
      end
      if ($urandom_range(99) < 5 && file_buf.size() >= 12)
         file_buf[$urandom_range(11)] ^= 8'(1 << $urandom_range(7));
   endfunction

   function automatic void build_mpeg_file();
      logic [1:0] version;
      logic [7:0] second;
      logic [7:0] third;
      file_buf.delete();
      repeat ($urandom_range(12)) file_buf.push_back(noise_byte());
      version = 2'($urandom_range(2));
      if (version != 0)
         version++;
      second = {3'b111, version, 2'($urandom_range(3, 1)), 1'($urandom())};
      third  = {4'($urandom_range(14, 1)), 2'($urandom_range(2)), 2'($urandom())};
      if ($urandom_range(9) == 0)
         second = random_byte();
      if ($urandom_range(9) == 0)
         third = random_byte();
      file_buf.push_back(8'hff);
      file_buf.push_back(second);
      file_buf.push_back(third);
      repeat ($urandom_range(6)) file_buf.push_back(noise_byte());
   endfunction

   function automatic void build_noise_file(input int unsigned max_len);
      file_buf.delete();
      repeat ($urandom_range(max_len, 1)) file_buf.push_back(noise_byte());
   endfunction

   task automatic test_wave_verdicts();
      start_wave();
      push_fmt(16, 16'd1, 16'd2, 32'd44100, 16'd16);
      push_chunk(DATA_ID, 4, 4);
      send_file();
      start_wave();
      push_chunk(LIST_ID, 5, 6);
      push_fmt(18, 16'hffff, 16'hffff, 32'hffff_ffff, 16'hffff);
      send_file();
      start_wave();
      push_fmt(16, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000);
      send_file();
      start_wave();
      push_chunk(JUNK_ID, 0, 0);
      push_fmt(17, 16'h0003, 16'h0001, 32'd96000, 16'd24);
      trim_file(1);
      send_file();
      start_wave();
      push_fmt(0, '0, '0, '0, '0);
      send_file();
      start_wave();
      push_fmt(8, 16'd1, 16'd1, 32'd8000, '0);
      send_file();
      start_wave();
      push_fmt(8, 16'd1, 16'd1, 32'd8000, '0);
      trim_file(2);
      send_file();
      start_wave();
      push_fmt(16, 16'd1, 16'd2, 32'd48000, 16'd16);
      trim_file(6);
      send_file();
      start_wave();
      push_chunk(JUNK_ID, 3, 3);
      send_file();
      start_wave();
      push_chunk(JUNK_ID, 3, 4);
      send_file();
      start_wave();
      push_chunk(JUNK_ID, 32'hffff_ffff, 6);
      send_file();
      start_wave();
      push_text(acs_pkg::FMT_ID);
      trim_file(1);
      send_file();
      start_wave();
      send_file();
      set_file('{8'h52, 8'h49, 8'h46, 8'h46});
      send_file();
      start_wave();
      file_buf[11] = 8'h58;
      push_fmt(16, 16'd1, 16'd2, 32'd44100, 16'd16);
      send_file();
      start_wave();
      push_chunk(JUNK_ID, 4, 0);
      push_text(32'hfffb_9000);
      send_file();
   endtask

   task automatic test_mpeg_verdicts();
      set_file('{8'hff, 8'hfb, 8'h90, 8'h00});
      send_file();
      set_file('{8'h12, 8'h34, 8'h56, 8'hff, 8'he2, 8'h14, 8'h00});
      send_file();
      set_file('{8'hff, 8'hff, 8'hfb, 8'h90, 8'h00});
      send_file();
      set_file('{8'hff, 8'hfb, 8'h90});
      send_file();
      set_file('{8'hff, 8'hea, 8'h90, 8'h00});
      send_file();
      set_file('{8'hff, 8'hf9, 8'h90, 8'h00});
      send_file();
      set_file('{8'hff, 8'hfb, 8'h00, 8'h00});
      send_file();
      set_file('{8'hff, 8'hfb, 8'hf0, 8'h00});
      send_file();
      set_file('{8'hff, 8'hfb, 8'h9c, 8'h00});
      send_file();
      set_file('{8'hff, 8'hdb, 8'h90, 8'h00});
      send_file();
      set_file('{8'h00});
      send_file();
      set_file('{8'hff});
      send_file();
      set_file('{8'h52, 8'h49, 8'h46, 8'h46, 8'hff, 8'hfb, 8'h90, 8'h00, 8'h11});
      send_file();
   endtask

   task automatic test_scan_limit();
      write_scan_limit(32'd4);
      set_file('{8'hff, 8'hfb, 8'h90, 8'h00});
      send_file();
      set_file('{8'h00, 8'hff, 8'hfb, 8'h90, 8'h00});
      send_file();
      write_scan_limit(32'd5);
      set_file('{8'h00, 8'hff, 8'hfb, 8'h90, 8'h00});
      send_file();
      set_file('{8'h00, 8'h00, 8'hff, 8'hfb, 8'h90, 8'h00});
      send_file();
      write_scan_limit(32'hffff_ffff);
      build_noise_file(30);
      push_text(32'hfffb_9000);
      send_file();
      write_scan_limit(acs_pkg::SCAN_LIMIT_RESET);
      build_noise_file(8);
      push_text(32'hfff3_5444);
      send_file();
   endtask

   task automatic run_random_files(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input logic [31:0] limit);
      int unsigned start_count;
      int unsigned files;
      int unsigned pick;
      write_scan_limit(limit);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start_count    = bytes_sent;
      files          = 0;
      while (bytes_sent - start_count < PHASE_BYTES || files < 4) begin
         pick = $urandom_range(99);
         if (pick < 50)
            build_wave_file();
         else if (pick < 80)
            build_mpeg_file();
         else
            build_noise_file(24);
         send_file();
         files++;
      end
      drain();
   endtask

   task automatic test_random_traffic();
      run_random_files(0, 0, 32'hffff_ffff);
      run_random_files(84, 0, $urandom_range(40, 4));
      run_random_files(0, 84, 32'd4);
      run_random_files(14, 14, acs_pkg::SCAN_LIMIT_RESET);
   endtask

   task automatic test_backpressure();
      write_scan_limit($urandom_range(64, 4));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      repeat (20) begin
         if ($urandom_range(1) == 1)
            build_mpeg_file();
         else
            build_noise_file(4);
         send_file();
      end
      drain();
   endtask

   initial begin
      scan_limit_m = acs_pkg::SCAN_LIMIT_RESET;
      clear_parse_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_wave_verdicts();
      test_mpeg_verdicts();
      drain();
      test_scan_limit();
      test_random_traffic();
      test_backpressure();
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

endmodule
